// ===== rtl/pfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

  localparam int unsigned WIDTH      = 128;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 7;
  localparam int unsigned PAGE_W     = 4;
  localparam int unsigned BIT_W      = 3;
  localparam int unsigned ADDR_IN_W  = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_PLOT = 2'd0,
    FUNC_RECT = 2'd1,
    FUNC_FILL = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  localparam logic [1:0] ORIENT_CW  = 2'd1;
  localparam logic [1:0] ORIENT_CCW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;

  localparam logic [BIT_W-1:0] BIT_MAX   = 3'h7;
  localparam logic [7:0]       FULL_BYTE = 8'hFF;

  localparam logic [7:0] FIRST_MASK [8] = '{
    8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE
  };
  localparam logic [7:0] LAST_MASK [8] = '{
    8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_FILL,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    func_e                op;
    logic [1:0]           mode;
    logic [COL_W-1:0]     col_hi;
    logic [COL_W-1:0]     col_lo;
    logic [ROW_W-1:0]     row_lo;
    logic [ROW_W-1:0]     row_hi;
    logic [7:0]           pattern;
    logic [ADDR_IN_W-1:0] byte_addr;
  } cmd_t;

  // bits b..7 set
  function automatic logic [7:0] mask_from(input logic [BIT_W-1:0] b);
    logic [BIT_W-1:0] n;
    n = BIT_W'(4'd8 - {1'b0, b});
    if (b == '0) begin
      return FULL_BYTE;
    end
    return FIRST_MASK[n];
  endfunction

  // bits 0..e set
  function automatic logic [7:0] mask_upto(input logic [BIT_W-1:0] e);
    logic [BIT_W-1:0] n;
    n = e + 3'd1;
    if (e == BIT_MAX) begin
      return FULL_BYTE;
    end
    return LAST_MASK[n];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] x1;
  logic [6:0] y1;
  logic [6:0] x2;
  logic [6:0] y2;
  logic [7:0] fill_pattern;
  logic [9:0] byte_addr;

  modport source (
    output valid, func, x1, y1, x2, y2, fill_pattern, byte_addr,
    input  ready
  );
  modport sink (
    input  valid, func, x1, y1, x2, y2, fill_pattern, byte_addr,
    output ready
  );
endinterface

interface pfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] done_op;

  modport source (
    output valid, read_data, done_op,
    input  ready
  );
  modport sink (
    input  valid, read_data, done_op,
    output ready
  );
endinterface

interface pfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfb_cmd_if.sink       cmd_i,
  pfb_cfg_if.sink       cfg_i,
  input  logic          hold_i,
  input  logic          full_i,
  output logic          push_o,
  output pfb_pkg::cmd_t cmd_o
);
  import pfb_pkg::*;

  logic [1:0] orient_q, orient_d;
  logic [1:0] mode_q, mode_d;
  logic       swap;
  logic [ROW_W-1:0] r1, r2;
  logic [COL_W-1:0] c1, c2;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = !full_i && !hold_i;
  assign push_o      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    orient_d = orient_q;
    mode_d   = mode_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ORIENT: orient_d = cfg_i.data[1:0];
        REG_MODE:   mode_d   = cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= '0;
      mode_q   <= MODE_SET;
    end else begin
      orient_q <= orient_d;
      mode_q   <= mode_d;
    end
  end

  // classify: pick row and column axes, order the corners
  always_comb begin
    swap = (orient_q == ORIENT_CW) || (orient_q == ORIENT_CCW);
    if (swap) begin
      r1 = cmd_i.x1;
      r2 = cmd_i.x2;
      c1 = cmd_i.y1;
      c2 = cmd_i.y2;
    end else begin
      r1 = cmd_i.y1;
      r2 = cmd_i.y2;
      c1 = cmd_i.x1;
      c2 = cmd_i.x2;
    end
    cmd_o.op        = func_e'(cmd_i.func);
    cmd_o.mode      = mode_q;
    cmd_o.pattern   = cmd_i.fill_pattern;
    cmd_o.byte_addr = cmd_i.byte_addr;
    if (func_e'(cmd_i.func) == FUNC_PLOT) begin
      // a single pixel is a one by one rectangle
      cmd_o.col_hi = c1;
      cmd_o.col_lo = c1;
      cmd_o.row_lo = r1;
      cmd_o.row_hi = r1;
    end else begin
      cmd_o.col_hi = (c1 > c2) ? c1 : c2;
      cmd_o.col_lo = (c1 > c2) ? c2 : c1;
      cmd_o.row_lo = (r1 < r2) ? r1 : r2;
      cmd_o.row_hi = (r1 < r2) ? r2 : r1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfb_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pfb_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output pfb_pkg::cmd_t head_o
);
  import pfb_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfb_back #(
  parameter int unsigned HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  pfb_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          clearing_o,
  pfb_res_if.source     res_o
);
  import pfb_pkg::*;

  localparam int unsigned STORE_BYTES = WIDTH * HEIGHT / 8;
  localparam int unsigned PAGE_COUNT  = HEIGHT / 8;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam logic [PAGE_W:0]    PAGE_CNT_L  = (PAGE_W + 1)'(PAGE_COUNT);
  localparam logic [PAGE_W:0]    PAGE_LAST_L = (PAGE_W + 1)'(PAGE_COUNT - 1);
  localparam logic [ADDR_IN_W:0] STORE_L     = (ADDR_IN_W + 1)'(STORE_BYTES);
  localparam logic [AW-1:0]      SWEEP_LAST  = AW'(STORE_BYTES - 1);

  logic [7:0] frame_q [STORE_BYTES];
  logic [7:0] rdata_q;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic              res_valid_q, res_valid_d;
  logic [7:0]        res_data_q, res_data_d;
  func_e             res_op_q, res_op_d;

  logic [AW-1:0]     rd_addr, wa;
  logic [7:0]        wd;
  logic              we;
  logic              finish;
  logic              slot_free;
  logic              page_last, page_in, col_last, read_ok, sweep_last;
  logic [BIT_W-1:0]  sbit, ebit;
  logic [7:0]        mask, modified, result_data;
  logic [PAGE_W+COL_W-1:0] byte_full, head_full;

  assign clearing_o = state_q == ST_CLEAR;
  assign slot_free  = !res_valid_q || res_o.ready;

  assign res_o.valid     = res_valid_q;
  assign res_o.read_data = res_data_q;
  assign res_o.done_op   = res_op_q;

  always_comb begin
    byte_full  = {page_q, col_q};
    head_full  = {head_i.row_lo[ROW_W-1:BIT_W], head_i.col_hi};
    page_last  = (page_q == cmd_q.row_hi[ROW_W-1:BIT_W]) || ({1'b0, page_q} >= PAGE_LAST_L);
    page_in    = {1'b0, page_q} < PAGE_CNT_L;
    col_last   = col_q == cmd_q.col_lo;
    read_ok    = {1'b0, cmd_q.byte_addr} < STORE_L;
    sweep_last = sweep_q == SWEEP_LAST;
    sbit = (page_q == cmd_q.row_lo[ROW_W-1:BIT_W]) ? cmd_q.row_lo[BIT_W-1:0] : '0;
    ebit = (page_q == cmd_q.row_hi[ROW_W-1:BIT_W]) ? cmd_q.row_hi[BIT_W-1:0] : BIT_MAX;
    mask = mask_from(sbit) & mask_upto(ebit);
    case (cmd_q.mode)
      MODE_CLEAR:  modified = rdata_q & ~mask;
      MODE_INVERT: modified = rdata_q ^ mask;
      default:     modified = rdata_q | mask;
    endcase
    result_data = (cmd_q.op == FUNC_READ && read_ok) ? rdata_q : 8'h00;
    if (state_q == ST_IDLE) begin
      rd_addr = (head_i.op == FUNC_READ) ? head_i.byte_addr[AW-1:0] : head_full[AW-1:0];
    end else begin
      rd_addr = (cmd_q.op == FUNC_READ) ? cmd_q.byte_addr[AW-1:0] : byte_full[AW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    col_d   = col_q;
    page_d  = page_q;
    sweep_d = sweep_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    wa      = byte_full[AW-1:0];
    wd      = modified;
    finish  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we      = 1'b1;
        wa      = sweep_q;
        wd      = 8'h00;
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          col_d   = head_i.col_hi;
          page_d  = head_i.row_lo[ROW_W-1:BIT_W];
          sweep_d = '0;
          state_d = (head_i.op == FUNC_FILL) ? ST_FILL : ST_WR;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (cmd_q.op == FUNC_READ) begin
          finish = 1'b1;
        end else begin
          we = page_in;
          if (page_last) begin
            if (col_last) begin
              finish = 1'b1;
            end else begin
              col_d   = col_q - 1'b1;
              page_d  = cmd_q.row_lo[ROW_W-1:BIT_W];
              state_d = ST_RD;
            end
          end else begin
            page_d  = page_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_FILL: begin
        we      = 1'b1;
        wa      = sweep_q;
        wd      = cmd_q.pattern;
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          finish = 1'b1;
        end
      end
      ST_DONE: begin
        finish = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
    if (finish) begin
      state_d = slot_free ? ST_IDLE : ST_DONE;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q && !res_o.ready;
    res_data_d  = res_data_q;
    res_op_d    = res_op_q;
    if (finish && slot_free) begin
      res_valid_d = 1'b1;
      res_data_d  = result_data;
      res_op_d    = cmd_q.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    col_q      <= col_d;
    page_q     <= page_d;
    res_data_q <= res_data_d;
    res_op_q   <= res_op_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      frame_q[wa] <= wd;
    end
    rdata_q <= frame_q[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/page_framebuffer_draw_engine.sv =====
// order of work: a plot reads its byte from the frame memory, then writes it back; a read
//   returns the byte (zero beyond the buffer); a rectangle reads and writes back each byte
//   walked (columns times pages touched); a buffer fill writes every byte. One command is
//   worked at a time; a two-entry queue takes new commands meanwhile; a held result stalls
// reset: all WIDTH*HEIGHT/8 frame memory bytes (1024 at the default) are cleared,
//   no command is accepted during that pass; configuration writes are always taken
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_draw_engine #(
  parameter int unsigned HEIGHT = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfb_cmd_if.sink   cmd_i,
  pfb_cfg_if.sink   cfg_i,
  pfb_res_if.source res_o
);
  import pfb_pkg::*;

  logic push, full, empty, pop, clearing;
  cmd_t cmd_new, cmd_head;

  pfb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .cfg_i  (cfg_i),
    .hold_i (clearing),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_new)
  );

  pfb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_new),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (cmd_head)
  );

  pfb_back #(
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (cmd_head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (res_o)
  );

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clearing && cmd_i.valid && cmd_i.ready))
    else $error("command accepted during clear pass");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("command queue underflow");

  a_no_result_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !res_o.valid)
    else $error("result pending during clear pass");

endmodule

`default_nettype wire

// ===== tb/sv/tb_page_framebuffer_draw_engine.sv =====
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_engine;
  import pfb_pkg::*;

  localparam int unsigned HEIGHT      = 64;
  localparam int unsigned STORE_BYTES = WIDTH * HEIGHT / 8;
  localparam int unsigned PAGES       = HEIGHT / 8;
  localparam longint     CYCLE_LIMIT = 20_000_000;
  localparam int         N_PHASES    = 10;
  localparam int         PHASE_ITEMS = 128;
  localparam int         HOLD_PHASE  = 2;
  localparam int         DRAIN_PHASE = 5;
  localparam int         HOLD_CYCLES = 400;
  localparam int         TAIL_CYCLES = 64;

  localparam logic [1:0] ORIENT_NORMAL = 2'd0;
  localparam logic [1:0] ORIENT_FLIP   = 2'd3;
  localparam logic [1:0] MODE_UNDEF    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [1:0] PHASE_ORIENT [N_PHASES] = '{
    ORIENT_NORMAL, ORIENT_CW, ORIENT_CCW, ORIENT_FLIP, ORIENT_NORMAL,
    ORIENT_CW, ORIENT_CCW, ORIENT_FLIP, ORIENT_NORMAL, ORIENT_CCW
  };
  localparam logic [1:0] PHASE_MODE [N_PHASES] = '{
    MODE_SET, MODE_INVERT, MODE_CLEAR, MODE_UNDEF, MODE_INVERT,
    MODE_SET, MODE_INVERT, MODE_CLEAR, MODE_CLEAR, MODE_SET
  };

  typedef struct {
    func_e      func;
    logic [6:0] x1;
    logic [6:0] y1;
    logic [6:0] x2;
    logic [6:0] y2;
    logic [7:0] pattern;
    logic [9:0] addr;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic [1:0] done_op;
  } draw_result_t;

  class frame_mirror;
    logic [7:0]   pixels [STORE_BYTES];
    logic [1:0]   orient;
    logic [1:0]   mode;
    draw_result_t due_results [$];
    int           errors;
    int           nonzero_reads;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      orient        = ORIENT_NORMAL;
      mode          = MODE_SET;
      errors        = 0;
      nonzero_reads = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ORIENT) orient = val[1:0];
      else if (idx == REG_MODE) mode = val[1:0];
    endfunction

    function bit swapped();
      return orient == ORIENT_CW || orient == ORIENT_CCW;
    endfunction

    function void paint(int unsigned addr, logic [7:0] bits);
      if (addr >= STORE_BYTES) return;
      case (mode)
        MODE_CLEAR:  pixels[addr] = pixels[addr] & ~bits;
        MODE_INVERT: pixels[addr] = pixels[addr] ^ bits;
        default:     pixels[addr] = pixels[addr] | bits;
      endcase
    endfunction

    function void plot(int unsigned x, int unsigned y);
      if (swapped()) paint((x >> 3) * WIDTH + y, 8'(1 << (x & 7)));
      else paint((y >> 3) * WIDTH + x, 8'(1 << (y & 7)));
    endfunction

    function void paint_column(int unsigned col, int unsigned top, int unsigned h);
      int unsigned page;
      int unsigned lead;
      logic [7:0]  bits;
      page = top >> 3;
      if ((top & 7) != 0) begin
        lead = 8 - (top & 7);
        bits = 8'hFF << (8 - lead);
        if (lead > h) bits = bits & (8'hFF >> (lead - h));
        paint(page * WIDTH + col, bits);
        if (lead > h) return;
        page++;
        h -= lead;
      end
      while (h > 7 && page < PAGES) begin
        paint(page * WIDTH + col, 8'hFF);
        page++;
        h -= 8;
      end
      if (h != 0 && h < 8) paint(page * WIDTH + col, 8'((1 << h) - 1));
    endfunction

    function void fill_rect(int unsigned x1, int unsigned y1, int unsigned x2,
                            int unsigned y2);
      int unsigned r1, r2, c1, c2, top, len, hi, lo;
      if (swapped()) begin
        r1 = x1; r2 = x2; c1 = y1; c2 = y2;
      end else begin
        r1 = y1; r2 = y2; c1 = x1; c2 = x2;
      end
      top = (r1 < r2) ? r1 : r2;
      len = ((r1 < r2) ? r2 - r1 : r1 - r2) + 1;
      hi  = (c1 > c2) ? c1 : c2;
      lo  = (c1 > c2) ? c2 : c1;
      for (int c = hi; c >= int'(lo); c--) paint_column(c, top, len);
    endfunction

    function void accept_cmd(draw_cmd_t c);
      draw_result_t r;
      r.read_data = 8'h00;
      r.done_op   = c.func;
      case (c.func)
        FUNC_PLOT: plot(c.x1, c.y1);
        FUNC_RECT: fill_rect(c.x1, c.y1, c.x2, c.y2);
        FUNC_FILL: foreach (pixels[i]) pixels[i] = c.pattern;
        default: begin
          if (c.addr < STORE_BYTES) r.read_data = pixels[c.addr];
          if (r.read_data != 8'h00) nonzero_reads++;
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] rd, logic [1:0] op);
      draw_result_t exp_r;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: read_data %02h done_op %0d", rd, op);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      if (rd !== exp_r.read_data) begin
        $error("read_data: expected %02h, actual %02h", exp_r.read_data, rd);
        errors++;
      end
      if (op !== exp_r.done_op) begin
        $error("done_op: expected %0d, actual %0d", exp_r.done_op, op);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pfb_cmd_if cmd_if ();
  pfb_cfg_if cfg_if ();
  pfb_res_if res_if ();

  page_framebuffer_draw_engine #(.HEIGHT(HEIGHT)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  frame_mirror mirror = new();
  draw_cmd_t   seen_cmd;
  longint      cycle_count;
  int          func_count [4];
  int          cfg_writes;
  int          sink_stall_pct;
  int          send_gap_pct;
  bit          sink_hold_req;
  logic [6:0]  last_x;
  logic [6:0]  last_y;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transaction monitor: results first, then register writes, then commands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) mirror.check_result(res_if.read_data, res_if.done_op);
      if (cfg_if.valid && cfg_if.ready) begin
        mirror.write_reg(cfg_if.index, cfg_if.data);
        cfg_writes++;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen_cmd.func    = func_e'(cmd_if.func);
        seen_cmd.x1      = cmd_if.x1;
        seen_cmd.y1      = cmd_if.y1;
        seen_cmd.x2      = cmd_if.x2;
        seen_cmd.y2      = cmd_if.y2;
        seen_cmd.pattern = cmd_if.fill_pattern;
        seen_cmd.addr    = cmd_if.byte_addr;
        mirror.accept_cmd(seen_cmd);
        func_count[cmd_if.func]++;
      end
    end
  end

  function automatic int gap_len();
    return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
  endfunction

  initial begin : result_sink
    int gap_left;
    gap_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        gap_left      = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end else if (gap_left == 0 && $urandom_range(99, 0) < sink_stall_pct) begin
        gap_left = gap_len();
      end
      if (gap_left > 0) begin
        res_if.ready <= 1'b0;
        gap_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_cmd(input draw_cmd_t c);
    @(negedge clk_i);
    cmd_if.valid        <= 1'b1;
    cmd_if.func         <= c.func;
    cmd_if.x1           <= c.x1;
    cmd_if.y1           <= c.y1;
    cmd_if.x2           <= c.x2;
    cmd_if.y2           <= c.y2;
    cmd_if.fill_pattern <= c.pattern;
    cmd_if.byte_addr    <= c.addr;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic idle_cmd(input int n);
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (mirror.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= {6'($urandom), val};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic issue(input func_e f, input int x1, input int y1, input int x2,
                       input int y2, input int pat, input int addr);
    draw_cmd_t c;
    c.func    = f;
    c.x1      = 7'(x1);
    c.y1      = 7'(y1);
    c.x2      = 7'(x2);
    c.y2      = 7'(y2);
    c.pattern = 8'(pat);
    c.addr    = 10'(addr);
    send_cmd(c);
  endtask

  function automatic logic [6:0] coord();
    return ($urandom_range(1, 0) == 0) ? 7'($urandom_range(63, 0)) : 7'($urandom);
  endfunction

  function automatic logic [6:0] near(input logic [6:0] v);
    int t;
    t = int'(v) + $urandom_range(16, 0) - 8;
    if (t < 0) t = 0;
    if (t > 127) t = 127;
    return 7'(t);
  endfunction

  function automatic draw_cmd_t make_random_cmd();
    draw_cmd_t c;
    int        sel;
    sel       = $urandom_range(99, 0);
    c.x1      = 7'($urandom);
    c.y1      = 7'($urandom);
    c.x2      = 7'($urandom);
    c.y2      = 7'($urandom);
    c.pattern = 8'($urandom);
    c.addr    = 10'($urandom);
    if (sel < 30) begin
      c.func = FUNC_PLOT;
      c.x1   = coord();
      c.y1   = coord();
    end else if (sel < 50) begin
      c.func = FUNC_RECT;
      if ($urandom_range(99, 0) < 85) begin
        c.x1 = coord();
        c.y1 = coord();
        c.x2 = near(c.x1);
        c.y2 = near(c.y1);
      end
    end else if (sel < 53) begin
      c.func = FUNC_FILL;
    end else begin
      c.func = FUNC_READ;
      if ($urandom_range(99, 0) < 60) begin
        c.addr = ($urandom_range(1, 0) == 0) ? {last_y[5:3], last_x} : {last_x[5:3], last_y};
      end
    end
    if (c.func == FUNC_PLOT || c.func == FUNC_RECT) begin
      last_x = c.x1;
      last_y = c.y1;
    end
    return c;
  endfunction

  initial begin : stimulus
    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.func         = FUNC_PLOT;
    cmd_if.x1           = '0;
    cmd_if.y1           = '0;
    cmd_if.x2           = '0;
    cmd_if.y2           = '0;
    cmd_if.fill_pattern = '0;
    cmd_if.byte_addr    = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_ORIENT;
    cfg_if.data         = '0;
    res_if.ready        = 1'b0;
    cfg_writes          = 0;
    func_count          = '{default: 0};
    sink_stall_pct      = 0;
    send_gap_pct        = 0;
    sink_hold_req       = 1'b0;
    last_x              = '0;
    last_y              = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, bottom edge, partial bytes, out-of-buffer runs, fills
    write_reg(REG_ORIENT, ORIENT_NORMAL);
    write_reg(REG_MODE, MODE_SET);
    write_reg(REG_SPARE_A, MODE_INVERT);
    write_reg(REG_SPARE_B, ORIENT_CW);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 0);
    issue(FUNC_READ, 127, 127, 127, 127, 255, 1023);
    issue(FUNC_PLOT, 0, 0, 0, 0, 0, 0);
    issue(FUNC_PLOT, 127, 63, 0, 0, 0, 0);
    issue(FUNC_PLOT, 127, 127, 0, 0, 0, 0);
    issue(FUNC_PLOT, 3, 64, 0, 0, 0, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 7 * 128 + 127);
    issue(FUNC_RECT, 12, 20, 10, 3, 0, 0);
    issue(FUNC_RECT, 20, 2, 20, 5, 0, 0);
    issue(FUNC_RECT, 30, 60, 31, 127, 0, 0);
    issue(FUNC_RECT, 40, 100, 41, 70, 0, 0);
    issue(FUNC_RECT, 50, 8, 50, 23, 0, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 128 + 11);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 7 * 128 + 30);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 20);
    issue(FUNC_RECT, 0, 0, 127, 63, 0, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 512);
    issue(FUNC_FILL, 0, 0, 0, 0, 8'hA5, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 1023);
    issue(FUNC_FILL, 0, 0, 0, 0, 8'hFF, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 300);
    issue(FUNC_FILL, 0, 0, 0, 0, 8'h00, 0);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 300);
    idle_cmd(1);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_ORIENT, PHASE_ORIENT[p]);
      write_reg(REG_MODE, PHASE_MODE[p]);
      if (p == 3) write_reg(REG_SPARE_B, MODE_CLEAR);
      if (p == 7) write_reg(REG_SPARE_A, ORIENT_CCW);
      sink_stall_pct = (p == 0) ? 0 : 10 + 5 * p;
      send_gap_pct   = (p == 0 || p == HOLD_PHASE || p == 4) ? 0 : 30;
      if (p == HOLD_PHASE) sink_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == DRAIN_PHASE && i == PHASE_ITEMS / 2) begin
          idle_cmd(1);
          wait_drained();
        end
        send_cmd(make_random_cmd());
        if ($urandom_range(99, 0) < send_gap_pct) idle_cmd(gap_len());
      end
      idle_cmd(1);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("checked %0d plots, %0d rectangles, %0d buffer fills, %0d reads (%0d nonzero)",
             func_count[FUNC_PLOT], func_count[FUNC_RECT], func_count[FUNC_FILL],
             func_count[FUNC_READ], mirror.nonzero_reads);
    $display("%0d register writes over %0d orientation/mode settings, %0d cycles",
             cfg_writes, N_PHASES + 1, cycle_count);
    if (mirror.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
